>>> hw/rtl/pngsu_pkg.sv
// Shared constants, codes and types for the PNG scanline unfilter.
`default_nettype none
package pngsu_pkg;

    localparam int MAX_ROW_BYTES   = 8192;
    localparam int MAX_PIXEL_BYTES = 8;

    // Configuration field widths
    localparam int RB_W  = 14;
    localparam int PB_W  = 4;
    localparam int RC_W  = 16;
    localparam int ROW_W = 16;

    localparam int COL_W    = $clog2(MAX_ROW_BYTES);
    localparam int PB_IDX_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    // Wide enough for column + 1 and for the clamped row length
    localparam int CNT_W    = ((COL_W > RB_W) ? COL_W : RB_W) + 1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_BYTES   = 2'd0,
        REG_PIXEL_BYTES = 2'd1,
        REG_ROW_COUNT   = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filt_t;

    // One image byte on its way through the reconstruct stage
    typedef struct packed {
        logic [7:0]       x;
        filt_t            filt;
        logic             bad;
        logic             have_left;
        logic             row_nz;
        logic             row_end;
        logic             image_end;
        logic [COL_W-1:0] col;
    } s1_t;

endpackage
`default_nettype wire

>>> hw/rtl/pngsu_if.sv
// Stream and configuration channel interfaces for the PNG scanline unfilter.
`default_nettype none
interface pngsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface pngsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_value;
    logic       row_end;
    logic       image_end;
    logic       bad_filter;

    modport source (output valid, output pixel_value, output row_end,
                    output image_end, output bad_filter, input ready);
    modport sink   (input valid, input pixel_value, input row_end,
                    input image_end, input bad_filter, output ready);
endinterface

interface pngsu_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [pngsu_pkg::CFG_IDX_W-1:0]  index;
    logic [pngsu_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/pngsu_ram.sv
// Simple dual-port line buffer RAM with registered read data.
`default_nettype none
module pngsu_ram #(
    parameter int DEPTH = 8192,
    parameter int WIDTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/pngsu_recon.sv
// Reconstruct stage: neighbor histories and the five PNG predictors.
`default_nettype none
module pngsu_recon (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire pngsu_pkg::s1_t                   s1,
    input  wire logic [7:0]                       b_mem,
    input  wire logic [pngsu_pkg::PB_IDX_W-1:0]   pb_idx,
    input  wire logic                             push,
    output      logic [7:0]                       val
);

    logic [7:0] left_reg [pngsu_pkg::MAX_PIXEL_BYTES];
    logic [7:0] ul_reg   [pngsu_pkg::MAX_PIXEL_BYTES];
    logic [7:0] a, b, c, pred;
    logic [8:0] avg_sum;

    function automatic logic [7:0] paeth(input logic [7:0] pa_in, input logic [7:0] pb_in,
                                         input logic [7:0] pc_in);
        logic signed [10:0] sa, sb, sc, da, db, dc;
        logic [9:0]         ma, mb, mc;
        sa = $signed({3'b000, pa_in});
        sb = $signed({3'b000, pb_in});
        sc = $signed({3'b000, pc_in});
        // p - a = b - c, p - b = a - c, p - c = a + b - 2c
        da = sb - sc;
        db = sa - sc;
        dc = sa + sb - sc - sc;
        ma = da[10] ? 10'(-da) : 10'(da);
        mb = db[10] ? 10'(-db) : 10'(db);
        mc = dc[10] ? 10'(-dc) : 10'(dc);
        if (ma <= mb && ma <= mc)
            return pa_in;
        else if (mb <= mc)
            return pb_in;
        else
            return pc_in;
    endfunction

    always_comb
    begin
        a = s1.have_left ? left_reg[pb_idx] : 8'd0;
        b = s1.row_nz ? b_mem : 8'd0;
        c = (s1.have_left && s1.row_nz) ? ul_reg[pb_idx] : 8'd0;
        avg_sum = {1'b0, a} + {1'b0, b};
        case (s1.filt)
            pngsu_pkg::FILT_SUB:   pred = a;
            pngsu_pkg::FILT_UP:    pred = b;
            pngsu_pkg::FILT_AVG:   pred = avg_sum[8:1];
            pngsu_pkg::FILT_PAETH: pred = paeth(a, b, c);
            default:               pred = 8'd0;
        endcase
        val = s1.x + pred;
    end

    // Shift in newest byte at position zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pngsu_pkg::MAX_PIXEL_BYTES; i++)
            begin
                left_reg[i] <= 8'd0;
                ul_reg[i]   <= 8'd0;
            end
        end
        else if (push)
        begin
            left_reg[0] <= val;
            ul_reg[0]   <= b;
            for (int i = 1; i < pngsu_pkg::MAX_PIXEL_BYTES; i++)
            begin
                left_reg[i] <= left_reg[i-1];
                ul_reg[i]   <= ul_reg[i-1];
            end
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/png_scanline_unfilter.sv
// Top level of the PNG scanline unfilter: position tracking, stage and output registers.
// Accepted image bytes pass the stage register, then the output register. One input
// byte per cycle while the output does not stall, filter code bytes included; the rate
// is set by the left-neighbor loop in the reconstruct stage and the single line-buffer
// read port. Reset clears the position, the filter state and the neighbor histories and
// sets all three configuration registers to 1; the line buffer is not cleared.
`default_nettype none
module png_scanline_unfilter (
    input  wire logic clk,
    input  wire logic rst_n,
    pngsu_in_if.sink    din,
    pngsu_out_if.source dout,
    pngsu_cfg_if.sink   cfg
);

    localparam int CNT_W = pngsu_pkg::CNT_W;
    localparam int COL_W = pngsu_pkg::COL_W;
    localparam int ROW_W = pngsu_pkg::ROW_W;

    logic [pngsu_pkg::RB_W-1:0] row_bytes_reg;
    logic [pngsu_pkg::PB_W-1:0] pixel_bytes_reg;
    logic [pngsu_pkg::RC_W-1:0] row_count_reg;

    logic [COL_W-1:0]  column_reg;
    logic [ROW_W-1:0]  row_reg;
    logic              await_reg;
    pngsu_pkg::filt_t  filt_reg;
    logic              bad_reg;

    pngsu_pkg::s1_t    s1_reg, s1_next;
    logic              s1_v_reg;

    logic              out_v_reg;
    logic [7:0]        out_val_reg;
    logic              out_rend_reg, out_iend_reg, out_bad_reg;

    logic [CNT_W-1:0]  eff_rb, col_plus;
    logic [pngsu_pkg::PB_W-1:0] eff_pb;
    logic [pngsu_pkg::RC_W-1:0] eff_rc;
    logic [pngsu_pkg::PB_IDX_W-1:0] pb_idx;
    logic [ROW_W:0]    row_plus;
    logic              accept, data_acc, s1_adv, in_ready;
    logic [7:0]        b_mem, val;

    // Clamp the configuration to the legal ranges
    always_comb
    begin
        if (row_bytes_reg == '0)
            eff_rb = CNT_W'(1);
        else if (CNT_W'(row_bytes_reg) > CNT_W'(pngsu_pkg::MAX_ROW_BYTES))
            eff_rb = CNT_W'(pngsu_pkg::MAX_ROW_BYTES);
        else
            eff_rb = CNT_W'(row_bytes_reg);

        if (pixel_bytes_reg == '0)
            eff_pb = pngsu_pkg::PB_W'(1);
        else if (pixel_bytes_reg > pngsu_pkg::PB_W'(pngsu_pkg::MAX_PIXEL_BYTES))
            eff_pb = pngsu_pkg::PB_W'(pngsu_pkg::MAX_PIXEL_BYTES);
        else
            eff_pb = pixel_bytes_reg;

        eff_rc = (row_count_reg == '0) ? pngsu_pkg::RC_W'(1) : row_count_reg;
        pb_idx = pngsu_pkg::PB_IDX_W'(eff_pb - pngsu_pkg::PB_W'(1));
    end

    assign s1_adv   = s1_v_reg && (!out_v_reg || dout.ready);
    // The filter code between rows pushes the last byte of the previous row out of the
    // stage, so a line-buffer read never meets a pending write to the same column.
    assign in_ready = !s1_v_reg || s1_adv;
    assign din.ready = in_ready;
    assign accept   = din.valid && in_ready;
    assign data_acc = accept && !await_reg;
    assign cfg.ready = 1'b1;

    assign col_plus = CNT_W'(column_reg) + CNT_W'(1);
    assign row_plus = {1'b0, row_reg} + (ROW_W + 1)'(1);

    always_comb
    begin
        s1_next.x         = din.data_byte;
        s1_next.filt      = filt_reg;
        s1_next.bad       = bad_reg;
        s1_next.have_left = CNT_W'(column_reg) >= CNT_W'(eff_pb);
        s1_next.row_nz    = row_reg != '0;
        s1_next.row_end   = col_plus >= eff_rb;
        s1_next.image_end = s1_next.row_end && (row_plus >= (ROW_W + 1)'(eff_rc));
        s1_next.col       = column_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg   <= pngsu_pkg::RB_W'(1);
            pixel_bytes_reg <= pngsu_pkg::PB_W'(1);
            row_count_reg   <= pngsu_pkg::RC_W'(1);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                pngsu_pkg::REG_ROW_BYTES:   row_bytes_reg   <= cfg.data[pngsu_pkg::RB_W-1:0];
                pngsu_pkg::REG_PIXEL_BYTES: pixel_bytes_reg <= cfg.data[pngsu_pkg::PB_W-1:0];
                pngsu_pkg::REG_ROW_COUNT:   row_count_reg   <= cfg.data[pngsu_pkg::RC_W-1:0];
                default:                    ;
            endcase
        end
    end

    // Position and filter state at the accept side
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            row_reg    <= '0;
            await_reg  <= 1'b1;
            filt_reg   <= pngsu_pkg::FILT_NONE;
            bad_reg    <= 1'b0;
        end
        else if (accept)
        begin
            if (await_reg)
            begin
                await_reg  <= 1'b0;
                column_reg <= '0;
                if (din.data_byte > 8'(pngsu_pkg::FILT_PAETH))
                begin
                    filt_reg <= pngsu_pkg::FILT_NONE;
                    bad_reg  <= 1'b1;
                end
                else
                begin
                    filt_reg <= pngsu_pkg::filt_t'(din.data_byte[2:0]);
                    bad_reg  <= 1'b0;
                end
            end
            else if (s1_next.row_end)
            begin
                column_reg <= '0;
                await_reg  <= 1'b1;
                row_reg    <= s1_next.image_end ? '0 : row_plus[ROW_W-1:0];
            end
            else
            begin
                column_reg <= column_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_v_reg <= data_acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_acc)
        begin
            s1_reg <= s1_next;
        end
    end

    pngsu_ram #(
        .DEPTH (pngsu_pkg::MAX_ROW_BYTES),
        .WIDTH (8)
    ) u_linebuf (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_reg.col),
        .wdata (val),
        .re    (data_acc),
        .raddr (column_reg),
        .rdata (b_mem)
    );

    pngsu_recon u_recon (
        .clk    (clk),
        .rst_n  (rst_n),
        .s1     (s1_reg),
        .b_mem  (b_mem),
        .pb_idx (pb_idx),
        .push   (s1_adv),
        .val    (val)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (!out_v_reg || dout.ready)
        begin
            out_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_val_reg  <= val;
            out_rend_reg <= s1_reg.row_end;
            out_iend_reg <= s1_reg.image_end;
            out_bad_reg  <= s1_reg.bad;
        end
    end

    assign dout.valid       = out_v_reg;
    assign dout.pixel_value = out_val_reg;
    assign dout.row_end     = out_rend_reg;
    assign dout.image_end   = out_iend_reg;
    assign dout.bad_filter  = out_bad_reg;

endmodule
`default_nettype wire

>>> hw/rtl/pngsu_checker.sv
// Port-level assertions for the PNG scanline unfilter, bound to the top level.
`default_nettype none
module pngsu_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic row_end,
    input wire logic image_end,
    input wire logic bad_filter
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_iend_rend: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!image_end || row_end))
        else $error("image end without row end");

    // A fresh result follows an accepted item through the stage and output registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without matching item");

    a_bad_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !row_end |=>
            (!out_valid || bad_filter == $past(bad_filter)))
        else $error("bad filter flag changed within a row");

    // Accept while the output side is empty
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

endmodule

bind png_scanline_unfilter pngsu_checker u_pngsu_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (din.valid),
    .in_ready   (din.ready),
    .out_valid  (dout.valid),
    .out_ready  (dout.ready),
    .row_end    (dout.row_end),
    .image_end  (dout.image_end),
    .bad_filter (dout.bad_filter)
);
`default_nettype wire
